// ===== hdl/ngfe_pkg.sv =====
// Package for the NMEA GGA field extractor: character codes, field limits,
// operation codes and the slot decode result type. No dependencies.
package ngfe_pkg;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;  // ','
  localparam logic [7:0] CHAR_STAR   = 8'h2A;  // '*'

  localparam int FIELD_W = 5;
  localparam int POS_W   = 4;

  localparam logic [FIELD_W-1:0] FIELD_CHK = 5'd15;
  localparam logic [FIELD_W-1:0] FIELD_MAX = 5'd16;
  localparam logic [POS_W-1:0]   POS_MAX   = 4'd15;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic       hit;
    logic [1:0] sub_part;
    logic [2:0] char_slot;
  } slot_dec_t;

endpackage

// ===== hdl/ngfe_slot_decode.sv =====
// Slot window decode for the GGA field extractor: maps field number and
// byte position to sub part and character slot. Depends on ngfe_pkg.
module ngfe_slot_decode import ngfe_pkg::*; (
  input  logic [FIELD_W-1:0] field,
  input  logic [POS_W-1:0]   pos,
  output slot_dec_t          dec
);

  logic [POS_W-1:0] whole;
  logic [POS_W-1:0] pm1;
  logic [POS_W-1:0] pm3;
  logic [POS_W-1:0] pm4;
  logic [POS_W-1:0] pm5;

  assign pm1 = pos - 4'd1;
  assign pm3 = pos - 4'd3;
  assign pm4 = pos - 4'd4;
  assign pm5 = pos - 4'd5;

  always_comb begin
    dec   = '0;
    whole = '0;
    case (field)
      5'd1: begin
        if (pos <= 4'd2) begin
          dec = '{hit: 1'b1, sub_part: 2'd0, char_slot: pm1[2:0]};
        end else if (pos <= 4'd4) begin
          dec = '{hit: 1'b1, sub_part: 2'd1, char_slot: pm3[2:0]};
        end else if (pos <= 4'd9) begin
          dec = '{hit: 1'b1, sub_part: 2'd2, char_slot: pm5[2:0]};
        end
      end
      5'd2: begin
        if (pos <= 4'd2) begin
          dec = '{hit: 1'b1, sub_part: 2'd0, char_slot: pm1[2:0]};
        end else if (pos <= 4'd10) begin
          dec = '{hit: 1'b1, sub_part: 2'd1, char_slot: pm3[2:0]};
        end
      end
      5'd4: begin
        if (pos <= 4'd3) begin
          dec = '{hit: 1'b1, sub_part: 2'd0, char_slot: pm1[2:0]};
        end else if (pos <= 4'd11) begin
          dec = '{hit: 1'b1, sub_part: 2'd1, char_slot: pm4[2:0]};
        end
      end
      5'd3, 5'd5, 5'd6, 5'd10, 5'd12: whole = 4'd1;
      5'd7, 5'd15:                    whole = 4'd2;
      5'd8:                           whole = 4'd4;
      5'd9, 5'd11:                    whole = 4'd6;
      default:                        whole = 4'd0;
    endcase
    // whole-field windows: position zero never stores
    if (whole != 4'd0 && pos != 4'd0 && pos <= whole) begin
      dec = '{hit: 1'b1, sub_part: 2'd0, char_slot: pm1[2:0]};
    end
  end

endmodule

// ===== hdl/nmea_gga_field_extractor_unit.sv =====
// Top level of the NMEA GGA field extractor: sentence counters, result
// register and stream handshake. Depends on ngfe_pkg and ngfe_slot_decode.
//
// Usage:
//   Feed one sentence character per word on the in_ channel; in_tuser marks
//   the first character of a new sentence buffer and clears the field and
//   position counters before that character is looked at. Each input word
//   yields zero or one result word on the out_ channel: either a character
//   write (out_tuser = 0) addressed by field, sub part and slot, or a clear
//   of a whole empty field (out_tuser = 1). The clear of an empty field comes
//   out with the comma that closes it.
//   A result is registered and shows on out_ in the cycle after its input
//   word is accepted. Throughput: one word per cycle unless a result waits;
//   counter update and slot decode fit between counter and result registers.
//   Stalls: the result register holds its word while out_tready is low, and
//   in_tready drops only while a held result is still waiting, so a new word
//   enters in the same cycle that the old result leaves.
//   Reset: rst_n (synchronous, active low) clears the counters, the
//   separator flag and out_tvalid; no result is pending afterwards.
module nmea_gga_field_extractor_unit import ngfe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tuser,    // [0] sentence_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [3:0] field_number, [5:4] sub_part,
                                   // [8:6] char_slot, [16:9] char_value, rest 0
  output logic        out_tuser    // [0] op_kind
);

  // sentence state
  logic [FIELD_W-1:0] field_r, field_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               sep_r, sep_nxt;

  // result register
  logic               vld_r, vld_nxt;
  logic               kind_r, kind_nxt;
  logic [3:0]         fnum_r, fnum_nxt;
  logic [1:0]         sub_r, sub_nxt;
  logic [2:0]         slot_r, slot_nxt;
  logic [7:0]         val_r, val_nxt;

  // working copies after an optional sentence start
  logic [FIELD_W-1:0] field_cur;
  logic [POS_W-1:0]   pos_cur;
  logic               sep_cur;
  logic [FIELD_W-1:0] field_dec;
  logic [POS_W-1:0]   pos_inc;
  logic               accept;
  logic               clearable;
  slot_dec_t          dec;

  assign in_tready = !vld_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign field_cur = in_tuser ? '0 : field_r;
  assign pos_cur   = in_tuser ? '0 : pos_r;
  assign sep_cur   = in_tuser ? 1'b0 : sep_r;

  // '$' restarts the field count; the position keeps counting
  assign field_dec = (in_tdata == CHAR_DOLLAR) ? '0 : field_cur;
  assign pos_inc   = (pos_cur < POS_MAX) ? pos_cur + 4'd1 : pos_cur;

  assign clearable = (field_cur >= 5'd1 && field_cur <= 5'd12) || field_cur == FIELD_CHK;

  ngfe_slot_decode u_slot_decode (
    .field (field_dec),
    .pos   (pos_inc),
    .dec   (dec)
  );

  always_comb begin
    field_nxt = field_r;
    pos_nxt   = pos_r;
    sep_nxt   = sep_r;
    vld_nxt   = vld_r && !out_tready;
    kind_nxt  = kind_r;
    fnum_nxt  = fnum_r;
    sub_nxt   = sub_r;
    slot_nxt  = slot_r;
    val_nxt   = val_r;
    if (accept) begin
      if (in_tdata == CHAR_COMMA) begin
        // empty field: close it with a clear
        if (sep_cur && clearable) begin
          vld_nxt  = 1'b1;
          kind_nxt = OP_CLEAR;
          fnum_nxt = field_cur[3:0];
          sub_nxt  = '0;
          slot_nxt = '0;
          val_nxt  = '0;
        end
        field_nxt = (field_cur < FIELD_MAX) ? field_cur + 5'd1 : field_cur;
        pos_nxt   = '0;
        sep_nxt   = 1'b1;
      end else if (in_tdata == CHAR_STAR) begin
        field_nxt = FIELD_CHK;
        pos_nxt   = '0;
        sep_nxt   = 1'b1;
      end else begin
        field_nxt = field_dec;
        pos_nxt   = pos_inc;
        sep_nxt   = 1'b0;
        if (dec.hit) begin
          vld_nxt  = 1'b1;
          kind_nxt = OP_WRITE;
          fnum_nxt = field_dec[3:0];
          sub_nxt  = dec.sub_part;
          slot_nxt = dec.char_slot;
          val_nxt  = in_tdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r <= '0;
      pos_r   <= '0;
      sep_r   <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      field_r <= field_nxt;
      pos_r   <= pos_nxt;
      sep_r   <= sep_nxt;
      vld_r   <= vld_nxt;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    fnum_r <= fnum_nxt;
    sub_r  <= sub_nxt;
    slot_r <= slot_nxt;
    val_r  <= val_nxt;
  end

  assign out_tvalid = vld_r;
  assign out_tuser  = kind_r;
  assign out_tdata  = {7'd0, val_r, slot_r, sub_r, fnum_r};

endmodule

// ===== hdl/ngfe_checker.sv =====
// Port-level checker for the GGA field extractor, bound to the top level.
// Depends on ngfe_pkg for the operation codes.
module ngfe_checker import ngfe_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser
);

  // a stalled result word stays
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word dropped or changed during stall");

  // nothing pending right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // clears carry only a field number
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == OP_CLEAR |-> out_tdata[23:4] == 20'd0)
    else $error("clear word carries payload");

  // ignored fields never show up
  a_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3:0] != 4'd0 && out_tdata[3:0] != 4'd13
                   && out_tdata[3:0] != 4'd14)
    else $error("result for an ignored field");

  // checksum writes use two slots of the whole field
  a_chk: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == OP_WRITE && out_tdata[3:0] == 4'd15
      |-> out_tdata[5:4] == 2'd0 && out_tdata[8:7] == 2'd0)
    else $error("checksum write outside its window");

endmodule

bind nmea_gga_field_extractor_unit ngfe_checker u_ngfe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
